FILE: src/bsm_pkg.sv
// Shared types and constants for the bounding sphere merge pipeline.
package bsm_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 50;
    localparam int ROOT_W   = 25;
    localparam int REM_W    = 27;
    localparam int GROW_W   = 48;

    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_RT0   = 3;
    localparam int ST_RAD   = ST_RT0 + ROOT_W;
    localparam int ST_MUL   = ST_RAD + 1;
    localparam int ST_DV0   = ST_MUL + 1;
    localparam int ST_OUT   = ST_DV0 + DIFF_W;
    localparam int NUM_ST   = ST_OUT + 1;

    localparam logic [COORD_W-1:0] RADIUS_MAX = {COORD_W{1'b1}};
    localparam logic signed [DIFF_W+1:0] COORD_LO = -27'sd8388608;
    localparam logic signed [DIFF_W+1:0] COORD_HI = 27'sd8388607;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] a;
        logic [2:0][COORD_W-1:0] b;
        logic [2:0][DIFF_W-1:0]  mag;
        logic [2:0]              neg;
        logic [COORD_W-1:0]      r1;
        logic [COORD_W-1:0]      r2;
        logic [2:0][SQ_W-1:0]    sq;
        logic [GROW_W-1:0]       diffsq;
        logic [SQ_W-1:0]         sumsq;
        logic                    contain;
        logic                    overlap;
        logic [SQ_W-1:0]         rad_bits;
        logic [REM_W-1:0]        rt_rem;
        logic [ROOT_W-1:0]       root;
        logic [COORD_W-1:0]      rad;
        logic [ROOT_W-1:0]       grow;
        logic [GROW_W-1:0]       radsq;
        logic [GROW_W-1:0]       r1sq;
        logic [2:0][DIFF_W-1:0]  dv_rem;
        logic [2:0][DIFF_W-1:0]  dv_bits;
    } pipe_t;

endpackage

FILE: src/bounding_sphere_merge.sv
// Bounding sphere merge: fully pipelined enclosing sphere of two spheres.
//
//  channel   signals                                           direction
//  -------   -----------------------------------------------   ---------
//  input     valid, stall, first_*, second_*                   in (stall out)
//  output    out_valid, out_stall, merged_*, growth, overlapping out (stall in)
//
// One transaction enters per cycle while stall is low; the stages are 3 front stages, 25 square
// root stages (one root bit each), 2 radius/multiply stages, 25 divider stages (one
// quotient bit each) and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds while the output register is full and stalled.
module bounding_sphere_merge
    import bsm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid,
    output logic                       stall,
    input  logic signed [COORD_W-1:0]  first_x,
    input  logic signed [COORD_W-1:0]  first_y,
    input  logic signed [COORD_W-1:0]  first_z,
    input  logic [COORD_W-1:0]         first_radius,
    input  logic signed [COORD_W-1:0]  second_x,
    input  logic signed [COORD_W-1:0]  second_y,
    input  logic signed [COORD_W-1:0]  second_z,
    input  logic [COORD_W-1:0]         second_radius,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  merged_x,
    output logic signed [COORD_W-1:0]  merged_y,
    output logic signed [COORD_W-1:0]  merged_z,
    output logic [COORD_W-1:0]         merged_radius,
    output logic [GROW_W-1:0]          growth,
    output logic                       overlapping
);

    pipe_t               st_reg  [NUM_ST];
    pipe_t               st_next [NUM_ST];
    logic [NUM_ST-1:0]   vld_reg;
    logic [NUM_ST-1:0]   vld_next;
    logic                adv;

    logic signed [COORD_W-1:0] out_c_reg [3];
    logic signed [COORD_W-1:0] out_c_next [3];
    logic [COORD_W-1:0]        out_rad_reg;
    logic [GROW_W-1:0]         out_grow_reg;
    logic [GROW_W-1:0]         out_grow_next;
    logic                      out_ovl_reg;

    assign adv   = !(vld_reg[NUM_ST-1] && out_stall);
    assign stall = !adv;

    always_comb
    begin
        vld_next = {vld_reg[NUM_ST-2:0], valid};
    end

    always_comb
    begin
        for (int s = 0; s < NUM_ST; s++)
        begin : stage_calc
            logic signed [DIFF_W-1:0] dd;
            logic [COORD_W-1:0]       rdiff;
            logic [DIFF_W-1:0]        rsum;
            logic [SQ_W:0]            d2w;
            logic [REM_W+1:0]         rt_t;
            logic [REM_W+1:0]         rt_trial;
            logic [DIFF_W+1:0]        rf_sum;
            logic [ROOT_W-1:0]        rf;
            logic [DIFF_W:0]          dv_t;
            if (s == ST_IN)
            begin
                st_next[s] = '0;
                st_next[s].a  = {first_z, first_y, first_x};
                st_next[s].b  = {second_z, second_y, second_x};
                st_next[s].r1 = first_radius;
                st_next[s].r2 = second_radius;
                for (int i = 0; i < 3; i++)
                begin
                    dd = DIFF_W'($signed(st_next[s].b[i])) - DIFF_W'($signed(st_next[s].a[i]));
                    st_next[s].neg[i] = dd[DIFF_W-1];
                    st_next[s].mag[i] = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
                end
            end
            else
            begin
                st_next[s] = st_reg[s-1];
            end

            dd = '0; rdiff = '0; rsum = '0; d2w = '0; rt_t = '0; rt_trial = '0;
            rf_sum = '0; rf = '0; dv_t = '0;

            if (s == ST_SQ)
            begin
                for (int i = 0; i < 3; i++)
                    st_next[s].sq[i] = st_reg[s-1].mag[i] * st_reg[s-1].mag[i];
                rdiff = (st_reg[s-1].r2 > st_reg[s-1].r1) ? st_reg[s-1].r2 - st_reg[s-1].r1
                                                           : st_reg[s-1].r1 - st_reg[s-1].r2;
                rsum  = {1'b0, st_reg[s-1].r1} + {1'b0, st_reg[s-1].r2};
                st_next[s].diffsq = rdiff * rdiff;
                st_next[s].sumsq  = rsum * rsum;
            end
            else if (s == ST_SUM)
            begin
                d2w = {1'b0, st_reg[s-1].sq[0]} + {1'b0, st_reg[s-1].sq[1]}
                    + {1'b0, st_reg[s-1].sq[2]};
                st_next[s].contain  = ({3'b0, st_reg[s-1].diffsq} >= d2w);
                st_next[s].overlap  = (d2w < {1'b0, st_reg[s-1].sumsq});
                st_next[s].rad_bits = d2w[SQ_W-1:0];
                st_next[s].rt_rem   = '0;
                st_next[s].root     = '0;
            end
            else if (s >= ST_RT0 && s < ST_RAD)
            begin
                // one root bit per stage: bring down two radicand bits, try 4*root+1
                rt_t     = {st_reg[s-1].rt_rem, st_reg[s-1].rad_bits[SQ_W-1 -: 2]};
                rt_trial = {2'b0, st_reg[s-1].root, 2'b01};
                st_next[s].rad_bits = {st_reg[s-1].rad_bits[SQ_W-3:0], 2'b00};
                if (rt_t >= rt_trial)
                begin
                    st_next[s].rt_rem = REM_W'(rt_t - rt_trial);
                    st_next[s].root   = {st_reg[s-1].root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    st_next[s].rt_rem = REM_W'(rt_t);
                    st_next[s].root   = {st_reg[s-1].root[ROOT_W-2:0], 1'b0};
                end
            end
            else if (s == ST_RAD)
            begin
                rf_sum = {1'b0, st_reg[s-1].root} + {2'b0, st_reg[s-1].r1}
                       + {2'b0, st_reg[s-1].r2};
                rf = rf_sum[DIFF_W:1];
                st_next[s].grow = (rf > {1'b0, st_reg[s-1].r1})
                                ? rf - {1'b0, st_reg[s-1].r1} : '0;
                if (st_reg[s-1].contain)
                    st_next[s].rad = (st_reg[s-1].r1 > st_reg[s-1].r2)
                                   ? st_reg[s-1].r1 : st_reg[s-1].r2;
                else
                    st_next[s].rad = rf[ROOT_W-1] ? RADIUS_MAX : rf[COORD_W-1:0];
            end
            else if (s == ST_MUL)
            begin
                st_next[s].radsq = st_reg[s-1].rad * st_reg[s-1].rad;
                st_next[s].r1sq  = st_reg[s-1].r1 * st_reg[s-1].r1;
                for (int i = 0; i < 3; i++)
                begin
                    st_next[s].sq[i]      = st_reg[s-1].mag[i] * st_reg[s-1].grow;
                    st_next[s].dv_rem[i]  = st_next[s].sq[i][SQ_W-1:DIFF_W];
                    st_next[s].dv_bits[i] = st_next[s].sq[i][DIFF_W-1:0];
                end
            end
            else if (s >= ST_DV0 && s < ST_OUT)
            begin
                // restoring divide by the distance; quotient bits shift in at the bottom
                for (int i = 0; i < 3; i++)
                begin
                    dv_t = {st_reg[s-1].dv_rem[i], st_reg[s-1].dv_bits[i][DIFF_W-1]};
                    if (dv_t >= {1'b0, st_reg[s-1].root})
                    begin
                        st_next[s].dv_rem[i]  = DIFF_W'(dv_t - {1'b0, st_reg[s-1].root});
                        st_next[s].dv_bits[i] = {st_reg[s-1].dv_bits[i][DIFF_W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next[s].dv_rem[i]  = DIFF_W'(dv_t);
                        st_next[s].dv_bits[i] = {st_reg[s-1].dv_bits[i][DIFF_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // final centre, growth and selection
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin : lane_out
            logic signed [DIFF_W+1:0] off;
            logic signed [DIFF_W+1:0] cc;
            off = st_reg[ST_OUT-1].neg[i]
                ? -$signed({2'b0, st_reg[ST_OUT-1].dv_bits[i]})
                :  $signed({2'b0, st_reg[ST_OUT-1].dv_bits[i]});
            cc  = (DIFF_W+2)'($signed(st_reg[ST_OUT-1].a[i])) + off;
            if (cc < COORD_LO)
                cc = COORD_LO;
            if (cc > COORD_HI)
                cc = COORD_HI;
            if (st_reg[ST_OUT-1].contain)
                out_c_next[i] = (st_reg[ST_OUT-1].r1 > st_reg[ST_OUT-1].r2)
                              ? $signed(st_reg[ST_OUT-1].a[i])
                              : $signed(st_reg[ST_OUT-1].b[i]);
            else
                out_c_next[i] = cc[COORD_W-1:0];
        end
        out_grow_next = (st_reg[ST_OUT-1].rad >= st_reg[ST_OUT-1].r1)
                      ? st_reg[ST_OUT-1].radsq - st_reg[ST_OUT-1].r1sq : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NUM_ST; s++)
                st_reg[s] <= st_next[s];
            for (int i = 0; i < 3; i++)
                out_c_reg[i] <= out_c_next[i];
            out_rad_reg  <= st_reg[ST_OUT-1].rad;
            out_grow_reg <= out_grow_next;
            out_ovl_reg  <= st_reg[ST_OUT-1].overlap;
        end
    end

    assign out_valid     = vld_reg[NUM_ST-1];
    assign merged_x      = out_c_reg[0];
    assign merged_y      = out_c_reg[1];
    assign merged_z      = out_c_reg[2];
    assign merged_radius = out_rad_reg;
    assign growth        = out_grow_reg;
    assign overlapping   = out_ovl_reg;

endmodule
